FILE: hdl/sit_pkg.sv
// ============================================================================
// sit_pkg: shared types and constants of the string intern table
// Holds the transfer structs, the command passed from front to back, the
// result codes and the sizes of the line and table stores.
// ============================================================================
package sit_pkg;

    localparam int MAX_LEN     = 128;
    localparam int TABLE_BYTES = 4096;
    localparam int LINE_AW     = $clog2(MAX_LEN);
    localparam int TAB_AW      = $clog2(TABLE_BYTES);

    // Characters with a special meaning.
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_BLANK  = 8'd32;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_N      = 8'd110;
    localparam logic [7:0] CH_NUL    = 8'd0;

    // Result codes.
    localparam logic [2:0] ST_FOUND = 3'd0;
    localparam logic [2:0] ST_ADDED = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_EOF   = 3'd3;
    localparam logic [2:0] ST_SHORT = 3'd4;
    localparam logic [2:0] ST_FULL  = 3'd5;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] offset;
    } result_t;

    // Work handed from front to back: a ready status or a table lookup.
    typedef struct packed {
        logic               lookup;
        logic [2:0]         status;
        logic [LINE_AW-1:0] len;
    } cmd_t;

    // Write into the line store.
    typedef struct packed {
        logic               we;
        logic [LINE_AW-1:0] addr;
        logic [7:0]         data;
    } line_wr_t;

endpackage

FILE: hdl/string_intern_table.sv
// ============================================================================
// string_intern_table: string interning block
// Collects one text line per transfer sequence and returns its offset in
// a packed table of zero-terminated strings, adding the string if new.
// ============================================================================
// Bytes are taken one per cycle while a line is collected and the command
// queue is not full. At an end of line that needs a lookup, input stalls
// while the table engine walks the table byte by byte (registered read of
// the table memory, then compare), and on a miss appends the line byte by
// byte plus the terminator. Lines that give a ready status (empty, end of
// file, too short) pass through a two-entry command queue and cost no
// extra input stall.
// The table needs no clearing after reset.
module string_intern_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  sit_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output sit_pkg::result_t result
);

    sit_pkg::cmd_t     cmd, head;
    sit_pkg::line_wr_t line_wr;
    logic push, pop, q_empty, q_full, lookup_done;

    sit_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .q_full      (q_full),
        .lookup_done (lookup_done),
        .push        (push),
        .cmd         (cmd),
        .line_wr     (line_wr)
    );

    sit_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sit_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_wr      (line_wr),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .lookup_done  (lookup_done),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: hdl/sit_front.sv
// ============================================================================
// sit_front: line collector
// Accepts input bytes, skips leading blanks, resolves escapes, writes the
// line store and issues one command per finished line.
// ============================================================================
module sit_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  sit_pkg::item_t  item,
    input  logic            q_full,
    input  logic            lookup_done,
    output logic            push,
    output sit_pkg::cmd_t   cmd,
    output sit_pkg::line_wr_t line_wr
);

    logic [sit_pkg::LINE_AW-1:0] len_reg, len_next;
    logic [sit_pkg::LINE_AW-1:0] trim_reg, trim_next;
    logic leading_reg, leading_next;
    logic esc_reg, esc_next;
    logic ovf_reg, ovf_next;
    logic lock_reg, lock_next;
    logic accept, collect, finish, keep;

    // The line store is owned by the back end while a lookup runs.
    assign item_stall = q_full || lock_reg;
    assign accept     = item_valid && !item_stall;

    // Classify the byte and update the line state.
    always_comb
    begin
        len_next     = len_reg;
        trim_next    = trim_reg;
        leading_next = leading_reg;
        esc_next     = esc_reg;
        ovf_next     = ovf_reg;
        lock_next    = lock_reg;
        collect      = 1'b0;
        finish       = 1'b0;
        keep         = 1'b0;
        push         = 1'b0;
        cmd          = '0;
        line_wr      = '0;
        if (lookup_done)
        begin
            lock_next = 1'b0;
        end
        if (accept)
        begin
            if (leading_reg)
            begin
                if (item.end_of_file)
                begin
                    push       = 1'b1;
                    cmd.status = sit_pkg::ST_EOF;
                end
                else if (item.ch == sit_pkg::CH_NL)
                begin
                    push       = 1'b1;
                    cmd.status = sit_pkg::ST_EMPTY;
                end
                else if (item.ch != sit_pkg::CH_BLANK)
                begin
                    leading_next = 1'b0;
                    collect      = 1'b1;
                end
            end
            else
            begin
                collect = 1'b1;
            end

            if (collect)
            begin
                if (item.end_of_file)
                begin
                    finish = 1'b1;
                end
                else if (item.ch == sit_pkg::CH_BSLASH)
                begin
                    keep     = 1'b1;
                    esc_next = 1'b1;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (item.ch == sit_pkg::CH_N)
                    begin
                        // The stored backslash becomes a newline.
                        if (!ovf_reg && len_reg != '0)
                        begin
                            line_wr.we   = 1'b1;
                            line_wr.addr = len_reg - 1'b1;
                            line_wr.data = sit_pkg::CH_NL;
                        end
                    end
                    else
                    begin
                        keep = (item.ch != sit_pkg::CH_NUL);
                    end
                end
                else if (item.ch == sit_pkg::CH_NL)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    keep = (item.ch != sit_pkg::CH_NUL);
                end
            end

            // Store the byte while room is left.
            if (keep)
            begin
                if (!ovf_reg && len_reg < sit_pkg::LINE_AW'(sit_pkg::MAX_LEN - 1))
                begin
                    line_wr.we   = 1'b1;
                    line_wr.addr = len_reg;
                    line_wr.data = item.ch;
                    len_next     = len_reg + 1'b1;
                    if (item.ch != sit_pkg::CH_BLANK)
                    begin
                        trim_next = len_reg + 1'b1;
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end

            // End of line: trailing blanks are already trimmed by trim_reg.
            if (finish)
            begin
                push = 1'b1;
                if (trim_reg < sit_pkg::LINE_AW'(2))
                begin
                    cmd.status = sit_pkg::ST_SHORT;
                end
                else
                begin
                    cmd.lookup = 1'b1;
                    cmd.len    = trim_reg;
                    lock_next  = 1'b1;
                end
                len_next     = '0;
                trim_next    = '0;
                leading_next = 1'b1;
                esc_next     = 1'b0;
                ovf_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            trim_reg    <= '0;
            leading_reg <= 1'b1;
            esc_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            lock_reg    <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            trim_reg    <= trim_next;
            leading_reg <= leading_next;
            esc_reg     <= esc_next;
            ovf_reg     <= ovf_next;
            lock_reg    <= lock_next;
        end
    end

endmodule

FILE: hdl/sit_queue.sv
// ============================================================================
// sit_queue: command queue
// Two-entry queue of commands between the line collector and the table
// engine.
// ============================================================================
module sit_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sit_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sit_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    sit_pkg::cmd_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/sit_back.sv
// ============================================================================
// sit_back: table engine
// Walks the packed string table for a collected line, appends it on a
// miss and drives the registered result.
// ============================================================================
module sit_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sit_pkg::line_wr_t line_wr,
    input  sit_pkg::cmd_t     head,
    input  logic              q_empty,
    output logic              pop,
    output logic              lookup_done,
    output logic              result_valid,
    input  logic              result_stall,
    output sit_pkg::result_t  result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_ARD,
        S_AWR
    } state_t;

    state_t state_reg;
    logic [7:0] tab_mem  [sit_pkg::TABLE_BYTES];
    logic [7:0] line_mem [sit_pkg::MAX_LEN];
    logic [7:0] tab_q, line_q;
    logic [sit_pkg::TAB_AW:0]    fill_reg, p_reg, p_inc;
    logic [sit_pkg::TAB_AW-1:0]  start_reg, wr_addr;
    logic [sit_pkg::LINE_AW-1:0] k_reg, len_reg;
    logic [sit_pkg::TAB_AW+1:0]  need;
    logic match_reg, out_free, tab_we;
    logic [7:0] tab_wdata;
    logic direct_pop, cmp_hit, table_short, lookup_end;

    assign out_free  = !result_valid || !result_stall;
    assign pop       = (state_reg == S_IDLE) && !q_empty && out_free;
    assign p_inc     = p_reg + 1'b1;
    assign wr_addr   = fill_reg[sit_pkg::TAB_AW-1:0] + sit_pkg::TAB_AW'(k_reg);
    assign tab_we    = (state_reg == S_AWR);
    assign tab_wdata = (k_reg == len_reg) ? sit_pkg::CH_NUL : line_q;
    assign need      = (sit_pkg::TAB_AW+2)'(fill_reg) + (sit_pkg::TAB_AW+2)'(len_reg)
                       + (sit_pkg::TAB_AW+2)'(1);

    // Ends of a lookup: a hit, a full table at the end of the walk, or the
    // terminator of an appended string written.
    assign direct_pop  = pop && !head.lookup;
    assign cmp_hit     = match_reg && k_reg == len_reg && tab_q == sit_pkg::CH_NUL;
    assign table_short = need > (sit_pkg::TAB_AW+2)'(sit_pkg::TABLE_BYTES);
    assign lookup_end  = ((state_reg == S_CMP) && (cmp_hit || (p_inc == fill_reg && table_short)))
                         || ((state_reg == S_AWR) && k_reg == len_reg);

    // Line store: written by the collector, read by the engine.
    always_ff @(posedge clk)
    begin
        if (line_wr.we)
        begin
            line_mem[line_wr.addr] <= line_wr.data;
        end
        line_q <= line_mem[k_reg];
    end

    // Table store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[wr_addr] <= tab_wdata;
        end
        tab_q <= tab_mem[p_reg[sit_pkg::TAB_AW-1:0]];
    end

    // Sequencer with the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            p_reg        <= '0;
            start_reg    <= '0;
            k_reg        <= '0;
            len_reg      <= '0;
            match_reg    <= 1'b0;
            lookup_done  <= 1'b0;
            result_valid <= 1'b0;
            result       <= '0;
        end
        else
        begin
            lookup_done  <= lookup_end;
            result_valid <= direct_pop || lookup_end || (result_valid && result_stall);
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (!head.lookup)
                        begin
                            result.status <= head.status;
                            result.offset <= '0;
                        end
                        else
                        begin
                            len_reg   <= head.len;
                            p_reg     <= '0;
                            start_reg <= '0;
                            k_reg     <= '0;
                            match_reg <= 1'b1;
                            if (fill_reg == '0)
                            begin
                                state_reg <= S_ARD;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (cmp_hit)
                    begin
                        // The line equals the string starting at start_reg.
                        result.status <= sit_pkg::ST_FOUND;
                        result.offset <= 12'(start_reg);
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        p_reg <= p_inc;
                        if (p_inc == fill_reg)
                        begin
                            k_reg <= '0;
                            if (table_short)
                            begin
                                result.status <= sit_pkg::ST_FULL;
                                result.offset <= '0;
                                state_reg     <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_ARD;
                            end
                        end
                        else
                        begin
                            if (tab_q == sit_pkg::CH_NUL)
                            begin
                                start_reg <= p_inc[sit_pkg::TAB_AW-1:0];
                                k_reg     <= '0;
                                match_reg <= 1'b1;
                            end
                            else if (match_reg && k_reg != len_reg && tab_q == line_q)
                            begin
                                k_reg <= k_reg + 1'b1;
                            end
                            else
                            begin
                                match_reg <= 1'b0;
                            end
                            state_reg <= S_RD;
                        end
                    end
                end
                S_ARD:
                begin
                    state_reg <= S_AWR;
                end
                S_AWR:
                begin
                    if (k_reg == len_reg)
                    begin
                        // Terminator written: the string is in.
                        result.status <= sit_pkg::ST_ADDED;
                        result.offset <= 12'(fill_reg);
                        fill_reg      <= need[sit_pkg::TAB_AW:0];
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_ARD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/sit_checker.sv
// ============================================================================
// sit_props: port checks of the string intern table
// Watches the top-level ports over time and is bound to the top level.
// ============================================================================
module sit_props (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input sit_pkg::result_t result
);

    // A stalled result holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Only found and added results carry an offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == sit_pkg::ST_EMPTY
            || result.status == sit_pkg::ST_EOF
            || result.status == sit_pkg::ST_SHORT
            || result.status == sit_pkg::ST_FULL) |-> result.offset == 12'd0)
        else $error("offset set on a result without a string");

    // Result codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status <= sit_pkg::ST_FULL)
        else $error("undefined result code");

endmodule

bind string_intern_table sit_props u_sit_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
